>>> sv/mie_pkg.sv
package mie_pkg;

  localparam int FIELD_BITS = 63;

  typedef struct packed {
    logic [FIELD_BITS-1:0] value;
    logic [FIELD_BITS-1:0] modulus;
  } in_beat_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] inverse;
    logic                  error;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_UPD,
    ST_FIN
  } state_t;

endpackage

>>> sv/modular_inverse_ext_euclid_top.sv
// Modular inverse by the extended Euclidean algorithm.
// Input beat: value and modulus; result beat: inverse of value mod modulus
// and an error flag. The error flag is set, with inverse 0, for a zero
// modulus or when value and modulus share a factor. Value 0 or 1 gives 1.
// Both channels use valid/stall; a beat moves when valid is high and stall
// is low. in_stall is high from the accepted beat until the result has been
// loaded into the output register, so one item is in work at a time.
// Each Euclid step runs through one shared restoring divider that also
// accumulates quotient times coefficient, one quotient bit per cycle.
// Each step passes through the check, divide and update states; a zero
// modulus goes straight to the final state. Operands of 63 bits take about
// 90 Euclid steps at most. The next beat can be taken in the cycle after
// the load.
// The result waits in an output register; a new item may be accepted while
// it is held by out_stall, and the next result waits in the final state
// until the register is free. Reset (rst_n low, synchronous) drops any item
// in work and any pending result.
module modular_inverse_ext_euclid_top #(
  parameter int WORD_BITS = 63
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mie_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mie_pkg::out_beat_t out_data
);

  localparam int W     = WORD_BITS;
  localparam int CW    = WORD_BITS + 1;
  localparam int CNT_W = $clog2(WORD_BITS);
  localparam int FB    = mie_pkg::FIELD_BITS;

  mie_pkg::state_t state_r, state_nxt;

  logic [W-1:0]     a_r, a_nxt;
  logic [W-1:0]     m_r, m_nxt;
  logic [W-1:0]     m0_r, m0_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     sh_r, sh_nxt;
  logic [CW-1:0]    cp_r, cp_nxt;
  logic [CW-1:0]    cc_r, cc_nxt;
  logic [CW-1:0]    prod_r, prod_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             err_r, err_nxt;

  logic               out_valid_r;
  mie_pkg::out_beat_t out_data_r;
  logic               load_out;
  logic [W-1:0]       inv_res;

  logic [W:0]   trial;
  logic [W+1:0] diff;
  logic         ge;
  logic [W-1:0] fix_sum;

  assign in_stall  = (state_r != mie_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Shared step unit: one restoring divide bit and one shift-add of q * c_prev
  assign trial    = {rem_r, sh_r[W-1]};
  assign diff     = {1'b0, trial} - {2'b00, m_r};
  assign ge       = !diff[W+1];
  assign fix_sum  = cc_r[W-1:0] + m0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mie_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    m_nxt     = m_r;
    m0_nxt    = m0_r;
    rem_nxt   = rem_r;
    sh_nxt    = sh_r;
    cp_nxt    = cp_r;
    cc_nxt    = cc_r;
    prod_nxt  = prod_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    load_out  = 1'b0;
    inv_res   = '0;
    unique case (state_r)
      mie_pkg::ST_IDLE: begin
        if (in_valid) begin
          a_nxt   = in_data.value[W-1:0];
          m_nxt   = in_data.modulus[W-1:0];
          m0_nxt  = in_data.modulus[W-1:0];
          cp_nxt  = '0;
          cc_nxt  = CW'(1);
          err_nxt = (in_data.modulus[W-1:0] == '0);
          state_nxt = (in_data.modulus[W-1:0] == '0) ? mie_pkg::ST_FIN
                                                      : mie_pkg::ST_CHECK;
        end
      end
      mie_pkg::ST_CHECK: begin
        if (a_r <= W'(1)) begin
          err_nxt   = 1'b0;
          state_nxt = mie_pkg::ST_FIN;
        end else if (m_r == '0) begin
          // gcd above one: no inverse
          err_nxt   = 1'b1;
          state_nxt = mie_pkg::ST_FIN;
        end else begin
          rem_nxt   = '0;
          sh_nxt    = a_r;
          prod_nxt  = '0;
          cnt_nxt   = CNT_W'(W - 1);
          state_nxt = mie_pkg::ST_DIV;
        end
      end
      mie_pkg::ST_DIV: begin
        rem_nxt  = ge ? diff[W-1:0] : trial[W-1:0];
        sh_nxt   = {sh_r[W-2:0], 1'b0};
        prod_nxt = {prod_r[CW-2:0], 1'b0} + (ge ? cp_r : '0);
        cnt_nxt  = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = mie_pkg::ST_UPD;
        end
      end
      mie_pkg::ST_UPD: begin
        a_nxt     = m_r;
        m_nxt     = rem_r;
        cp_nxt    = cc_r - prod_r;
        cc_nxt    = cp_r;
        state_nxt = mie_pkg::ST_CHECK;
      end
      mie_pkg::ST_FIN: begin
        if (err_r) begin
          inv_res = '0;
        end else if (cc_r[W]) begin
          // negative coefficient: fold back by the modulus
          inv_res = fix_sum;
        end else begin
          inv_res = cc_r[W-1:0];
        end
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = mie_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mie_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    m_r    <= m_nxt;
    m0_r   <= m0_nxt;
    rem_r  <= rem_nxt;
    sh_r   <= sh_nxt;
    cp_r   <= cp_nxt;
    cc_r   <= cc_nxt;
    prod_r <= prod_nxt;
    cnt_r  <= cnt_nxt;
    err_r  <= err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.inverse <= FB'(inv_res);
      out_data_r.error   <= err_r;
    end
  end

`ifndef SYNTHESIS
  a_err_zero_inv: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.error) |-> (out_data.inverse == '0))
    else $error("error beat carries a nonzero inverse");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again straight after an accepted beat");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mie_pkg::ST_DIV) |-> (m_r != '0))
    else $error("division started with a zero divisor");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while held");
`endif

endmodule

>>> tb/tb_modular_inverse_ext_euclid_top.sv
module tb_modular_inverse_ext_euclid_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  FIELD_BITS  = mie_pkg::FIELD_BITS;
  localparam int  WORD_BITS   = FIELD_BITS;
  localparam int  CYCLE_LIMIT = 4000000;
  localparam int  DRAIN_WAIT  = 6000;
  localparam int  RANDOM_PER_PHASE = 40;

  localparam logic [FIELD_BITS-1:0] WORD_MAX = '1;
  localparam logic [FIELD_BITS-1:0] FIB_91   = 63'd4660046610375530309;
  localparam logic [FIELD_BITS-1:0] FIB_92   = 63'd7540113804746346429;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  mie_pkg::in_beat_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  mie_pkg::out_beat_t out_data;

  mie_pkg::in_beat_t  pending_pairs[$];
  mie_pkg::out_beat_t inverse_expected[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches      = 0;
  int beats_sent      = 0;
  int results_checked = 0;
  int errors_seen     = 0;
  int cycles          = 0;

  modular_inverse_ext_euclid_top #(.WORD_BITS(WORD_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Extended Euclid with coefficients wrapping at 64 bits.
  function automatic mie_pkg::out_beat_t modinv_predict(mie_pkg::in_beat_t pair);
    logic [63:0]        a, m, m0, c_prev, c_cur, q, r, keep;
    mie_pkg::out_beat_t res;
    a = {1'b0, pair.value};
    m = {1'b0, pair.modulus};
    m0 = m;
    c_prev = 64'd0;
    c_cur = 64'd1;
    res.inverse = '0;
    res.error = 1'b1;
    if (m0 == 64'd0)
      return res;
    while (a > 64'd1) begin
      if (m == 64'd0)
        return res;
      q = a / m;
      r = a % m;
      a = m;
      m = r;
      keep = c_prev;
      c_prev = c_cur - q * c_prev;
      c_cur = keep;
    end
    // fold a negative coefficient back into range
    if (c_cur[63])
      c_cur = c_cur + m0;
    res.inverse = c_cur[FIELD_BITS-1:0];
    res.error = 1'b0;
    return res;
  endfunction

  function automatic logic [FIELD_BITS-1:0] rand_word(int bits);
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[FIELD_BITS-1:0] >> (FIELD_BITS - bits);
  endfunction

  function automatic mie_pkg::in_beat_t rand_pair();
    mie_pkg::in_beat_t pair;
    int                kind;
    logic [63:0]       g;
    kind = $urandom_range(0, 99);
    g = 64'($urandom_range(2, 1000));
    pair.value = rand_word($urandom_range(1, FIELD_BITS));
    pair.modulus = rand_word($urandom_range(1, FIELD_BITS));
    if (kind < 35) begin
      pair.value = rand_word(FIELD_BITS);
      pair.modulus = rand_word(FIELD_BITS);
    end else if (kind < 70) begin
      // keep the random widths
    end else if (kind < 82) begin
      // common factor: no inverse
      pair.value = FIELD_BITS'({24'd0, rand_word(40)} * g);
      pair.modulus = FIELD_BITS'({24'd0, rand_word(40)} * g);
    end else if (kind < 90) begin
      pair.value = FIELD_BITS'($urandom_range(0, 1));
    end else if (kind < 95) begin
      pair.modulus = FIELD_BITS'($urandom_range(0, 1));
    end else begin
      pair.modulus = pair.value;
    end
    return pair;
  endfunction

  task automatic queue_pair(logic [FIELD_BITS-1:0] value, logic [FIELD_BITS-1:0] modulus);
    mie_pkg::in_beat_t pair;
    pair.value = value;
    pair.modulus = modulus;
    pending_pairs.push_back(pair);
  endtask

  task automatic report_mismatch(string what);
    $display("%0t mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic drain_all();
    do @(negedge clk);
    while (pending_pairs.size() != 0 || in_valid || inverse_expected.size() != 0);
  endtask

  // driver: advance to the next beat once the current one has gone
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        inverse_expected.push_back(modinv_predict(in_data));
        beats_sent++;
      end
      if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data <= pending_pairs.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n)
      out_stall <= 1'b0;
    else
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    mie_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (inverse_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected result inverse=%0d error=%0b",
                                  out_data.inverse, out_data.error));
      end else begin
        want = inverse_expected.pop_front();
        if (out_data.inverse !== want.inverse)
          report_mismatch($sformatf("inverse got %0d want %0d",
                                    out_data.inverse, want.inverse));
        if (out_data.error !== want.error)
          report_mismatch($sformatf("error got %0b want %0b",
                                    out_data.error, want.error));
        if (want.error)
          errors_seen++;
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, inverse_expected.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 13;
    recv_stall_pct = 83;
    queue_pair('0, '0);
    queue_pair(63'd5, '0);
    queue_pair(WORD_MAX, '0);
    queue_pair('0, 63'd7);
    queue_pair(63'd1, 63'd7);
    queue_pair(63'd1, 63'd1);
    queue_pair('0, 63'd1);
    queue_pair(63'd5, 63'd1);
    queue_pair(63'd3, 63'd7);
    queue_pair(63'd100, 63'd7);
    queue_pair(63'd6, 63'd9);
    queue_pair(63'd12, 63'd18);
    queue_pair(63'd2, 63'h4000000000000000);
    queue_pair(63'h4000000000000000, 63'd3);
    queue_pair(WORD_MAX, WORD_MAX);
    queue_pair(WORD_MAX, WORD_MAX - 63'd1);
    queue_pair(WORD_MAX - 63'd1, WORD_MAX);
    queue_pair(WORD_MAX, 63'd1);
    queue_pair(WORD_MAX, 63'd2);
    queue_pair(63'd1, WORD_MAX);
    // consecutive Fibonacci numbers: longest Euclid chain
    queue_pair(FIB_91, FIB_92);
    queue_pair(FIB_92, FIB_91);
    for (int i = 0; i < RANDOM_PER_PHASE; i++)
      pending_pairs.push_back(rand_pair());
    // hold the sender until everything in flight has come back
    drain_all();

    send_idle_pct = 83;
    recv_stall_pct = 13;
    for (int i = 0; i < RANDOM_PER_PHASE; i++)
      pending_pairs.push_back(rand_pair());
    drain_all();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < RANDOM_PER_PHASE; i++)
      pending_pairs.push_back(rand_pair());
    drain_all();

    repeat (DRAIN_WAIT) @(posedge clk);
    $display("%0d pairs sent, %0d inverses checked, %0d of them flagged with no inverse",
             beats_sent, results_checked, errors_seen);
    $display("%0d mismatches over %0d cycles", mismatches, cycles);
    if (mismatches == 0 && inverse_expected.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> modular_inverse_ext_euclid_top.f
sv/mie_pkg.sv
sv/modular_inverse_ext_euclid_top.sv
tb/tb_modular_inverse_ext_euclid_top.sv
